// ===== hdl/fbpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared types, constants and helpers for the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int LINK_W     = $clog2(MAX_BLOCKS + 1);
	localparam int COUNT_W    = 7;
	localparam int SIZE_W     = 8;
	localparam int ADDR_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_COUNT  = 2'd0,
		REG_BLOCK_SIZE   = 2'd1,
		REG_BASE_ADDRESS = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

	typedef struct packed {
		req_kind_t   req_type;
		logic [5:0]  block_index;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  granted_index;
		logic [15:0] block_address;
	} rsp_t;

	// control bundle into the link memory
	typedef struct packed {
		logic              clear;
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [LINK_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} link_mem_req_t;

	// block count clamped to pool capacity
	function automatic logic [LINK_W-1:0] usable_blocks(input logic [COUNT_W-1:0] count);
		logic [LINK_W-1:0] n;
		if (32'(count) > MAX_BLOCKS) begin
			n = LINK_W'(MAX_BLOCKS);
		end else begin
			n = LINK_W'(count);
		end
		return n;
	endfunction

endpackage

// ===== hdl/fbpa_link_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_link_mem
// next-link store, one synchronous read port and one write port, with a
// valid bit per entry so a rebuild only has to clear the valid bits
// ----------------------------------------------------------------------------
module fbpa_link_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fbpa_pkg::link_mem_req_t       req,
	output logic [fbpa_pkg::LINK_W-1:0]   rdata
);
	import fbpa_pkg::*;

	logic [LINK_W-1:0]     mem [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] valid_q;
	logic [LINK_W-1:0]     mem_rd_s1;
	logic                  hit_s1;
	logic [IDX_W-1:0]      raddr_s1;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			mem_rd_s1 <= mem[req.raddr];
			raddr_s1  <= req.raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_s1  <= 1'b0;
		end else begin
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				hit_s1 <= valid_q[req.raddr];
			end
		end
	end

	// an unwritten entry i still links to block i - 1, i.e. holds i
	assign rdata = hit_s1 ? mem_rd_s1 : LINK_W'(raddr_s1);

endmodule

// ===== hdl/fixed_block_pool_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// the result sits in the output register in the cycle after transfer
// free, empty and bad-index requests leave the unit idle; a granted alloc holds off
//   new requests in ST_POP while the new head's link is read from the link memory
// reset: asynchronous, 64 blocks of 16 bytes at base 0, full free list at once
// a block_count write rebuilds the list through per-entry valid bits
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              req_valid,
	output logic                              req_stall,
	input  fbpa_pkg::req_t                    req_item,
	// response channel
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output fbpa_pkg::rsp_t                    rsp_item,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fbpa_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fbpa_pkg::*;

	// configuration registers
	logic [COUNT_W-1:0] block_count_q;
	logic [SIZE_W-1:0]  block_size_q;
	logic [ADDR_W-1:0]  base_address_q;

	// free list head, link form (index + 1, zero is null)
	logic [LINK_W-1:0]  head_q, head_d;

	state_t             state_q, state_d;

	// output register
	logic               rsp_valid_q;
	rsp_t               rsp_q, rsp_d;

	logic               accept;
	logic               cfg_write;
	logic               head_empty;
	logic [IDX_W-1:0]   granted;
	logic [IDX_W+SIZE_W-1:0] offset;
	logic [LINK_W-1:0]  usable;
	logic [LINK_W-1:0]  link_rdata;
	link_mem_req_t      mem_req;

	fbpa_link_mem u_link_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (link_rdata)
	);

	// nothing new while a pop waits on its link or the result is held
	assign req_stall = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_write = cfg_valid && cfg_ready;

	assign usable     = usable_blocks(block_count_q);
	assign head_empty = (head_q == '0) || (head_q > LINK_W'(MAX_BLOCKS));
	assign granted    = IDX_W'(head_q - LINK_W'(1));
	// narrow product, address wraps at 16 bits
	assign offset     = granted * block_size_q;

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		rsp_d        = rsp_q;
		mem_req      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rsp_d = '{status: STAT_DONE, granted_index: '0, block_address: '0};
					if (req_item.req_type == REQ_ALLOC) begin
						if (head_empty) begin
							rsp_d.status = STAT_EMPTY;
						end else begin
							// result is known now, only the new head has to wait
							rsp_d.granted_index = 6'(granted);
							rsp_d.block_address = base_address_q + ADDR_W'(offset);
							mem_req.re    = 1'b1;
							mem_req.raddr = granted;
							state_d       = ST_POP;
						end
					end else begin
						if (LINK_W'(req_item.block_index) >= usable) begin
							rsp_d.status = STAT_BAD_INDEX;
						end else begin
							// push: freed block links to old head
							mem_req.we    = 1'b1;
							mem_req.waddr = IDX_W'(req_item.block_index);
							mem_req.wdata = head_q;
							head_d        = LINK_W'(req_item.block_index) + LINK_W'(1);
						end
					end
				end
				if (cfg_write && cfg_index == REG_BLOCK_COUNT) begin
					// rebuild: highest block first, every link back to its default
					mem_req.clear = 1'b1;
					head_d        = usable_blocks(cfg_data[COUNT_W-1:0]);
				end
			end
			ST_POP: begin
				head_d  = link_rdata;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q         <= usable_blocks(COUNT_W'(64));
			block_count_q  <= COUNT_W'(64);
			block_size_q   <= SIZE_W'(16);
			base_address_q <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			head_q <= head_d;
			if (cfg_write) begin
				unique case (cfg_index)
					REG_BLOCK_COUNT:  block_count_q  <= cfg_data[COUNT_W-1:0];
					REG_BLOCK_SIZE:   block_size_q   <= cfg_data[SIZE_W-1:0];
					REG_BASE_ADDRESS: base_address_q <= cfg_data[ADDR_W-1:0];
					default: begin
						// index past the register list is dropped
					end
				endcase
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

endmodule

// ===== hdl/fbpa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_checker
// port-level checks on the allocator, bound to the top level
// ----------------------------------------------------------------------------
module fbpa_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  logic                              req_stall,
	input  logic                              rsp_valid,
	input  logic                              rsp_stall,
	input  fbpa_pkg::rsp_t                    rsp_item,
	input  logic                              cfg_ready
);
	import fbpa_pkg::*;

	// held response keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
		else $error("response changed while stalled");

	// every request transfer shows a response the cycle after
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("request transfer without response");

	// no new request while the output is full and stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while response blocked");

	// non-grant responses carry zero index and address
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.status != STAT_DONE |->
			rsp_item.granted_index == '0 && rsp_item.block_address == '0)
		else $error("error response with nonzero fields");

	// config port closed only while a pop is in flight, requests wait too
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> req_stall)
		else $error("request open while config port busy");

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_item  (rsp_item),
	.cfg_ready (cfg_ready)
);
